>>> design/rai_pkg.sv
// Package for the radix integer-to-ASCII converter.
// Holds the shared widths, radix limits, controller states, cell control struct
// and digit-to-character mapping. It depends on nothing else.
`default_nettype none

package rai_pkg;

  localparam int unsigned RADIX_W = 6;
  localparam int unsigned DIGIT_W = 6;
  localparam int unsigned CHAR_W  = 7;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 7'h30;
  localparam logic [CHAR_W-1:0] ASCII_A    = 7'h41;
  localparam logic [CHAR_W-1:0] ASCII_NINE = 7'h39;
  localparam logic [CHAR_W-1:0] ASCII_Z    = 7'h5A;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_e;

  // Control that the sequencer broadcasts to every digit cell.
  typedef struct packed {
    logic clr;
    logic shift;
  } cell_ctrl_t;

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] dx;
    dx = {1'b0, d};
    if (d < 6'd10) begin
      digit_to_ascii = ASCII_ZERO + dx;
    end else begin
      digit_to_ascii = ASCII_A + dx - 7'd10;
    end
  endfunction

endpackage

`default_nettype wire

>>> design/radix_integer_to_ascii.sv
// Conversion runs through the skewed digit chain in ST_CONV; then ST_EMIT shifts out
// one stored digit per step while leading zeros are dropped and characters leave.
// One value at a time: a new value is taken only when the controller is idle; a bad
// radix gives its single error request instead of characters.
// Reset: the radix returns to ten, the controller to idle and the output empties.
`default_nettype none

module radix_integer_to_ascii
  import rai_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 31
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    psel,
  input  wire                    penable,
  input  wire                    pwrite,
  input  wire  [2:0]             paddr,
  input  wire  [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  input  wire                    in_valid_i,
  output logic                   in_stall_o,
  input  wire  [VALUE_BITS-1:0]  value_i,
  output logic                   out_valid_o,
  input  wire                    out_stall_i,
  output logic [CHAR_W-1:0]      digit_char_o,
  output logic                   is_last_o,
  output logic                   radix_error_o
);

  localparam int unsigned CELLS     = VALUE_BITS;
  localparam int unsigned CNT_W     = $clog2(2 * VALUE_BITS);
  localparam int unsigned REM_W     = $clog2(CELLS);
  localparam int unsigned CONV_LAST = 2 * VALUE_BITS - 2;

  logic [RADIX_W-1:0]    radix_q;
  state_e                state_q, state_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [VALUE_BITS-1:0] value_q, value_d;
  logic [REM_W-1:0]      rem_q, rem_d;
  logic                  started_q, started_d;
  logic                  err_q, err_d;
  logic                  out_vld_q, out_vld_d;
  logic [CHAR_W-1:0]     out_char_q, out_char_d;
  logic                  out_last_q, out_last_d;
  logic                  out_err_q, out_err_d;

  cell_ctrl_t            cell_ctrl;
  logic                  feed_wave;
  logic [DIGIT_W-1:0]    dig   [CELLS];
  logic                  wave  [CELLS];
  logic                  carry [CELLS];

  logic accept, slot_free, radix_ok, last, emit, step;
  logic [DIGIT_W-1:0] top_digit;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr == 3'd0) ? {{(32-RADIX_W){1'b0}}, radix_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RADIX_RESET;
    end else if (psel && penable && pwrite && (paddr == 3'd0)) begin
      radix_q <= pwdata[RADIX_W-1:0];
    end
  end

  // Digit chain: cell 0 is least significant and takes the value bits MSB first.
  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    if (i == 0) begin : g_first
      rai_cell u_cell (
        .clk_i         (clk_i),
        .rst_ni        (rst_ni),
        .ctrl_i        (cell_ctrl),
        .radix_i       (radix_q),
        .wave_i        (feed_wave),
        .carry_i       (value_q[VALUE_BITS-1]),
        .shift_digit_i ({DIGIT_W{1'b0}}),
        .digit_o       (dig[i]),
        .wave_o        (wave[i]),
        .carry_o       (carry[i])
      );
    end else begin : g_next
      rai_cell u_cell (
        .clk_i         (clk_i),
        .rst_ni        (rst_ni),
        .ctrl_i        (cell_ctrl),
        .radix_i       (radix_q),
        .wave_i        (wave[i-1]),
        .carry_i       (carry[i-1]),
        .shift_digit_i (dig[i-1]),
        .digit_o       (dig[i]),
        .wave_o        (wave[i]),
        .carry_o       (carry[i])
      );
    end
  end

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign slot_free  = !out_vld_q || !out_stall_i;
  assign radix_ok   = (radix_q >= RADIX_MIN) && (radix_q <= RADIX_MAX);
  assign top_digit  = dig[CELLS-1];
  assign last       = (rem_q == '0);
  assign emit       = (top_digit != '0) || started_q || last;
  assign step       = !emit || slot_free;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    value_d    = value_q;
    rem_d      = rem_q;
    started_d  = started_q;
    err_d      = err_q;
    out_vld_d  = out_vld_q && out_stall_i;
    out_char_d = out_char_q;
    out_last_d = out_last_q;
    out_err_d  = out_err_q;
    cell_ctrl  = '0;
    feed_wave  = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cell_ctrl.clr = 1'b1;
          value_d       = value_i;
          cnt_d         = '0;
          rem_d         = REM_W'(CELLS - 1);
          started_d     = 1'b0;
          err_d         = !radix_ok;
          state_d       = radix_ok ? ST_CONV : ST_EMIT;
        end
      end
      ST_CONV: begin
        // Bits enter while cnt_q is below VALUE_BITS; the wave then travels up the chain to the top cell.
        feed_wave = (cnt_q < CNT_W'(VALUE_BITS));
        value_d   = value_q << 1;
        cnt_d     = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(CONV_LAST)) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (err_q) begin
          if (slot_free) begin
            out_vld_d  = 1'b1;
            out_char_d = '0;
            out_last_d = 1'b1;
            out_err_d  = 1'b1;
            state_d    = ST_IDLE;
          end
        end else if (step) begin
          // Leading zeros are shifted away without waiting for the output.
          cell_ctrl.shift = 1'b1;
          rem_d           = rem_q - 1'b1;
          if (emit) begin
            out_vld_d  = 1'b1;
            out_char_d = digit_to_ascii(top_digit);
            out_last_d = last;
            out_err_d  = 1'b0;
            started_d  = 1'b1;
          end
          if (last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q      <= cnt_d;
    value_q    <= value_d;
    rem_q      <= rem_d;
    started_q  <= started_d;
    err_q      <= err_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
    out_err_q  <= out_err_d;
  end

  assign out_valid_o   = out_vld_q;
  assign digit_char_o  = out_char_q;
  assign is_last_o     = out_last_q;
  assign radix_error_o = out_err_q;

`ifndef SYNTHESIS
  a_err_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && radix_error_o |-> is_last_o && (digit_char_o == '0))
    else $error("error request must be a lone final request with no character");

  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !radix_error_o |->
      ((digit_char_o >= ASCII_ZERO) && (digit_char_o <= ASCII_NINE)) ||
      ((digit_char_o >= ASCII_A) && (digit_char_o <= ASCII_Z)))
    else $error("character outside the digit alphabet");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wave[CELLS-1] |-> !carry[CELLS-1])
    else $error("carry left the most significant digit cell");

  // The top cell works on its last bit in the final conversion cycle, so only the
  // wave feeding it must be gone once emission starts.
  a_chain_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CONV) && (state_d == ST_EMIT) |=> !wave[CELLS-2])
    else $error("conversion ended with a wave still in the chain");
`endif

endmodule

`default_nettype wire

>>> design/rai_cell.sv
// One digit cell of the conversion chain: holds a single radix digit.
// Doubles its digit plus the carry from its lower neighbour, and shifts digits upward.
// Depends on rai_pkg.
`default_nettype none

module rai_cell
  import rai_pkg::*;
(
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire  cell_ctrl_t   ctrl_i,
  input  wire  [RADIX_W-1:0] radix_i,
  input  wire                wave_i,
  input  wire                carry_i,
  input  wire  [DIGIT_W-1:0] shift_digit_i,
  output logic [DIGIT_W-1:0] digit_o,
  output logic               wave_o,
  output logic               carry_o
);

  logic [DIGIT_W-1:0] digit_q, digit_d;
  logic               carry_q, carry_d;
  logic               wave_q, wave_d;
  logic [DIGIT_W:0]   dbl;
  logic [DIGIT_W:0]   diff;
  logic               wrap;

  always_comb begin
    // The low bit of the doubled digit is free, so the carry drops straight in.
    dbl  = {digit_q, carry_i};
    diff = dbl - {1'b0, radix_i};
    wrap = (dbl >= {1'b0, radix_i});

    digit_d = digit_q;
    if (ctrl_i.clr) begin
      digit_d = '0;
    end else if (ctrl_i.shift) begin
      digit_d = shift_digit_i;
    end else if (wave_i) begin
      digit_d = wrap ? diff[DIGIT_W-1:0] : dbl[DIGIT_W-1:0];
    end

    carry_d = wave_i & wrap;
    wave_d  = wave_i & ~ctrl_i.clr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_q <= 1'b0;
    end else begin
      wave_q <= wave_d;
    end
  end

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
    carry_q <= carry_d;
  end

  assign digit_o = digit_q;
  assign wave_o  = wave_q;
  assign carry_o = carry_q;

endmodule

`default_nettype wire
